[rtl/pei_pkg.sv]
// types, constants and helpers for the particle euler integrator
// no dependencies
package pei_pkg;

  localparam int ValueWidth = 32;
  localparam int FracBits   = 16;
  localparam int DtBits     = 20;
  localparam int DampBits   = 17;
  localparam int IdxBits    = 3;
  localparam int PwCount    = 20;
  localparam int PwIdxBits  = 5;

  localparam logic [DampBits-1:0] DampOne   = 17'd65536;
  localparam logic [DampBits-1:0] DampReset = 17'd64881;
  localparam logic [ValueWidth-1:0] InvMassReset = 32'd65536;

  typedef enum logic [1:0] {
    CMD_FORCE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_POS   = 2'd2,
    CMD_VEL   = 2'd3
  } cmd_t;

  typedef enum logic [IdxBits-1:0] {
    REG_INV_MASS = 3'd0,
    REG_DAMPING  = 3'd1,
    REG_ACCEL_X  = 3'd2,
    REG_ACCEL_Y  = 3'd3,
    REG_ACCEL_Z  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_SQRT,
    ST_FACT,
    ST_AXIS,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] vector_x;
    logic signed [31:0] vector_y;
    logic signed [31:0] vector_z;
    logic [19:0]        duration;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] position_z;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
  } out_item_t;

  function automatic logic signed [ValueWidth-1:0] sat(input logic signed [50:0] v);
    logic signed [50:0] hi;
    logic signed [50:0] lo;
    hi = 51'sd2147483647;
    lo = -51'sd2147483648;
    if (v > hi) begin
      sat = hi[ValueWidth-1:0];
    end else if (v < lo) begin
      sat = lo[ValueWidth-1:0];
    end else begin
      sat = v[ValueWidth-1:0];
    end
  endfunction

endpackage

[rtl/particle_euler_integrator.sv]
// particle euler integrator top level: state, sequencer, shared multiplier, root unit
// depends on pei_pkg
//
// One transaction is taken at a time. Force add and load commands go straight to the
// output state; an integrate step with movable mass and nonzero duration runs the
// squarings, 16 square roots in the bit-serial root unit, the damping factor and the
// three axes, each multiply through one registered 33x33 multiplier. A finished result
// waits in the output register while the next transaction is taken.
module particle_euler_integrator (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  pei_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pei_pkg::out_item_t  out_data
);

  pei_pkg::state_t state, state_next;

  logic signed [31:0] inv_mass;
  logic [16:0]        damping;
  logic signed [31:0] accel [3];
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] frc [3];
  logic [16:0]        pw [pei_pkg::PwCount];
  logic [19:0]        dt;
  logic [16:0]        fct;
  logic signed [31:0] acc_r;
  logic signed [65:0] prod;
  logic               ph;
  logic [4:0]         idx;
  logic [4:0]         cnt;
  logic [1:0]         ax;
  logic [1:0]         step;
  logic [33:0]        nsh;
  logic [19:0]        rem;
  logic [16:0]        root;

  logic [4:0]         rd_addr;
  logic [16:0]        pw_rd;
  logic signed [32:0] op_a, op_b;
  logic signed [49:0] sh;
  logic [19:0]        rem_sh;
  logic [18:0]        trial;
  logic               take;
  logic [19:0]        rem_nx;
  logic [16:0]        root_nx;
  logic               accept;
  logic               skip;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == pei_pkg::ST_IDLE);
  assign skip = (inv_mass <= 0) || (in_data.duration == '0);

  always_comb begin
    case (state)
      pei_pkg::ST_POW:  rd_addr = idx - 5'd1;
      pei_pkg::ST_SQRT: rd_addr = idx + 5'd1;
      default:          rd_addr = idx;
    endcase
  end
  assign pw_rd = pw[rd_addr];

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      pei_pkg::ST_POW: begin
        op_a = {16'b0, pw_rd};
        op_b = {16'b0, pw_rd};
      end
      pei_pkg::ST_FACT: begin
        op_a = {16'b0, fct};
        op_b = {16'b0, pw_rd};
      end
      pei_pkg::ST_AXIS: begin
        case (step)
          2'd0: begin
            op_a = {vel[ax][31], vel[ax]};
            op_b = {13'b0, dt};
          end
          2'd1: begin
            op_a = {frc[ax][31], frc[ax]};
            op_b = {inv_mass[31], inv_mass};
          end
          2'd2: begin
            op_a = {acc_r[31], acc_r};
            op_b = {13'b0, dt};
          end
          default: begin
            op_a = {vel[ax][31], vel[ax]};
            op_b = {16'b0, fct};
          end
        endcase
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign sh = prod[65:16];

  assign rem_sh  = {rem[17:0], nsh[33:32]};
  assign trial   = {root, 2'b01};
  assign take    = rem_sh >= {1'b0, trial};
  assign rem_nx  = take ? rem_sh - {1'b0, trial} : rem_sh;
  assign root_nx = {root[15:0], take};

  always_comb begin
    state_next = state;
    case (state)
      pei_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.command == pei_pkg::CMD_STEP && !skip) begin
            state_next = pei_pkg::ST_POW;
          end else begin
            state_next = pei_pkg::ST_OUT;
          end
        end
      end
      pei_pkg::ST_POW: begin
        if (ph && idx == 5'd19) begin
          state_next = pei_pkg::ST_SQRT;
        end
      end
      pei_pkg::ST_SQRT: begin
        if (ph && cnt == '0 && idx == '0) begin
          state_next = pei_pkg::ST_FACT;
        end
      end
      pei_pkg::ST_FACT: begin
        if (ph && idx == '0) begin
          state_next = pei_pkg::ST_AXIS;
        end
      end
      pei_pkg::ST_AXIS: begin
        if (ph && step == 2'd3 && ax == 2'd2) begin
          state_next = pei_pkg::ST_OUT;
        end
      end
      pei_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = pei_pkg::ST_IDLE;
        end
      end
      default: state_next = pei_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pei_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_mass <= pei_pkg::InvMassReset;
      damping  <= pei_pkg::DampReset;
      accel[0] <= '0;
      accel[1] <= '0;
      accel[2] <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        pei_pkg::REG_INV_MASS: inv_mass <= cfg_data;
        pei_pkg::REG_DAMPING: begin
          damping <= (cfg_data[16:0] > pei_pkg::DampOne) ? pei_pkg::DampOne : cfg_data[16:0];
        end
        pei_pkg::REG_ACCEL_X: accel[0] <= cfg_data;
        pei_pkg::REG_ACCEL_Y: accel[1] <= cfg_data;
        pei_pkg::REG_ACCEL_Z: accel[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath and sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
        frc[i] <= '0;
      end
      ph   <= 1'b0;
      idx  <= '0;
      cnt  <= '0;
      ax   <= '0;
      step <= '0;
    end else begin
      case (state)
        pei_pkg::ST_IDLE: begin
          ph <= 1'b0;
          if (accept) begin
            dt <= in_data.duration;
            case (in_data.command)
              pei_pkg::CMD_FORCE: begin
                frc[0] <= pei_pkg::sat(51'(frc[0]) + 51'(in_data.vector_x));
                frc[1] <= pei_pkg::sat(51'(frc[1]) + 51'(in_data.vector_y));
                frc[2] <= pei_pkg::sat(51'(frc[2]) + 51'(in_data.vector_z));
              end
              pei_pkg::CMD_POS: begin
                pos[0] <= in_data.vector_x;
                pos[1] <= in_data.vector_y;
                pos[2] <= in_data.vector_z;
              end
              pei_pkg::CMD_VEL: begin
                vel[0] <= in_data.vector_x;
                vel[1] <= in_data.vector_y;
                vel[2] <= in_data.vector_z;
              end
              default: begin
                pw[16] <= damping;
                idx    <= 5'd17;
              end
            endcase
          end
        end
        pei_pkg::ST_POW: begin
          ph <= !ph;
          if (!ph) begin
            prod <= op_a * op_b;
          end else begin
            pw[idx] <= prod[32:16];
            idx <= (idx == 5'd19) ? 5'd15 : idx + 5'd1;
          end
        end
        pei_pkg::ST_SQRT: begin
          if (!ph) begin
            nsh  <= {1'b0, pw_rd, 16'b0};
            rem  <= '0;
            root <= '0;
            cnt  <= 5'd16;
            ph   <= 1'b1;
          end else begin
            nsh  <= {nsh[31:0], 2'b00};
            rem  <= rem_nx;
            root <= root_nx;
            if (cnt == '0) begin
              pw[idx] <= root_nx;
              ph <= 1'b0;
              if (idx == '0) begin
                idx <= 5'd19;
                fct <= pei_pkg::DampOne;
              end else begin
                idx <= idx - 5'd1;
              end
            end else begin
              cnt <= cnt - 5'd1;
            end
          end
        end
        pei_pkg::ST_FACT: begin
          ph <= !ph;
          if (!ph) begin
            prod <= op_a * op_b;
          end else begin
            if (dt[idx]) begin
              fct <= prod[32:16];
            end
            if (idx == '0) begin
              ax   <= '0;
              step <= '0;
            end else begin
              idx <= idx - 5'd1;
            end
          end
        end
        pei_pkg::ST_AXIS: begin
          ph <= !ph;
          if (!ph) begin
            prod <= op_a * op_b;
          end else begin
            step <= step + 2'd1;
            case (step)
              2'd0: pos[ax] <= pei_pkg::sat(51'(pos[ax]) + 51'(sh));
              2'd1: acc_r <= pei_pkg::sat(51'(accel[ax]) + 51'(sh));
              2'd2: vel[ax] <= pei_pkg::sat(51'(vel[ax]) + 51'(sh));
              default: begin
                vel[ax] <= sh[31:0];
                frc[ax] <= '0;
                ax <= ax + 2'd1;
              end
            endcase
          end
        end
        default: ph <= 1'b0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == pei_pkg::ST_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        out_data.position_x <= pos[0];
        out_data.position_y <= pos[1];
        out_data.position_z <= pos[2];
        out_data.velocity_x <= vel[0];
        out_data.velocity_y <= vel[1];
        out_data.velocity_z <= vel[2];
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/pei_checker.sv]
// port-level checker for the particle euler integrator, bound to the top level
// depends on particle_euler_integrator ports
module pei_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // a held result stays until its transaction completes
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  // one transaction at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // reset empties the output
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind particle_euler_integrator pei_checker u_pei_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready)
);

[tb/particle_euler_integrator_tb.sv]
// self-checking testbench for the particle euler integrator
// depends on pei_pkg and particle_euler_integrator; holds its own predictor and scoreboard
module particle_euler_integrator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  class particle_scoreboard;
    logic signed [63:0] inv_mass;
    logic [63:0] damp;
    logic signed [63:0] acc[3];
    logic signed [63:0] pos[3];
    logic signed [63:0] vel[3];
    logic signed [63:0] frc[3];
    pei_pkg::out_item_t pending_states[$];
    int mismatches;

    function new();
      inv_mass = 65536;
      damp = 64881;
      mismatches = 0;
      for (int i = 0; i < 3; i++) begin
        acc[i] = 0; pos[i] = 0; vel[i] = 0; frc[i] = 0;
      end
    endfunction

    function logic signed [63:0] clip(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function logic [63:0] root(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [63:0] damp_factor(logic [19:0] dt);
      logic [63:0] pw[20];
      logic [63:0] f;
      f = 65536;
      pw[16] = damp;
      for (int b = 17; b < 20; b++) pw[b] = (pw[b-1] * pw[b-1]) >> 16;
      for (int b = 15; b >= 0; b--) pw[b] = root(pw[b+1] << 16);
      for (int b = 19; b >= 0; b--)
        if (dt[b]) f = (f * pw[b]) >> 16;
      return f;
    endfunction

    function void write_reg(pei_pkg::reg_idx_t idx, logic [31:0] d);
      case (idx)
        pei_pkg::REG_INV_MASS: inv_mass = $signed(d);
        pei_pkg::REG_DAMPING: damp = (d[16:0] > 17'd65536) ? 64'd65536 : {47'd0, d[16:0]};
        pei_pkg::REG_ACCEL_X: acc[0] = $signed(d);
        pei_pkg::REG_ACCEL_Y: acc[1] = $signed(d);
        pei_pkg::REG_ACCEL_Z: acc[2] = $signed(d);
        default: ;
      endcase
    endfunction

    function void note_input(pei_pkg::in_item_t t);
      logic signed [63:0] vec[3];
      logic signed [63:0] a, v, dt, f;
      pei_pkg::out_item_t e;
      vec[0] = t.vector_x; vec[1] = t.vector_y; vec[2] = t.vector_z;
      dt = {44'd0, t.duration};
      case (pei_pkg::cmd_t'(t.command))
        pei_pkg::CMD_FORCE: for (int i = 0; i < 3; i++) frc[i] = clip(frc[i] + vec[i]);
        pei_pkg::CMD_POS: for (int i = 0; i < 3; i++) pos[i] = vec[i];
        pei_pkg::CMD_VEL: for (int i = 0; i < 3; i++) vel[i] = vec[i];
        default: begin
          if (inv_mass > 0 && dt != 0) begin
            f = damp_factor(t.duration);
            for (int i = 0; i < 3; i++) begin
              pos[i] = clip(pos[i] + ((vel[i] * dt) >>> 16));
              a = clip(acc[i] + ((frc[i] * inv_mass) >>> 16));
              v = clip(vel[i] + ((a * dt) >>> 16));
              vel[i] = (v * f) >>> 16;
              frc[i] = 0;
            end
          end
        end
      endcase
      e.position_x = pos[0][31:0]; e.position_y = pos[1][31:0]; e.position_z = pos[2][31:0];
      e.velocity_x = vel[0][31:0]; e.velocity_y = vel[1][31:0]; e.velocity_z = vel[2][31:0];
      pending_states.push_back(e);
    endfunction

    function void check_result(pei_pkg::out_item_t got);
      pei_pkg::out_item_t e;
      if (pending_states.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %h", got);
        return;
      end
      e = pending_states.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch pos exp %h %h %h got %h %h %h",
                   e.position_x, e.position_y, e.position_z,
                   got.position_x, got.position_y, got.position_z);
          $display("         vel exp %h %h %h got %h %h %h",
                   e.velocity_x, e.velocity_y, e.velocity_z,
                   got.velocity_x, got.velocity_y, got.velocity_z);
        end
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0, in_ready;
  pei_pkg::in_item_t in_data = '0;
  logic out_valid, out_ready = 0;
  pei_pkg::out_item_t out_data;

  particle_scoreboard sb = new();
  int cycle_count = 0;
  bit calm = 0;
  bit hold_off = 0;
  bit done = 0;

  particle_euler_integrator dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (out_valid && out_ready) sb.check_result(out_data);
    if (cycle_count > 3000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver side: random stall bursts, a long hold-off on request
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        for (int i = 0; i < 3000; i++) @(negedge clk);
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 16);
        repeat (n) @(negedge clk);
      end else begin
        out_ready <= 1;
        @(negedge clk);
      end
    end
  end

  task automatic send_item(pei_pkg::in_item_t t);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 16);
      repeat (n) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(t);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_states.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_cfg(pei_pkg::reg_idx_t idx, logic [31:0] d);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_write <= 0;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 262143) - 131072;
      3: return $urandom_range(0, 33554431) - 16777216;
      default: return $urandom;
    endcase
  endfunction

  function automatic pei_pkg::in_item_t rand_item();
    pei_pkg::in_item_t t;
    t.vector_x = rand_val();
    t.vector_y = rand_val();
    t.vector_z = rand_val();
    t.duration = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 131072));
    if ($urandom_range(0, 15) == 0) t.duration = 0;
    t.command = $urandom_range(0, 3) == 0 ? pei_pkg::CMD_STEP : 2'($urandom_range(0, 3));
    return t;
  endfunction

  function automatic pei_pkg::in_item_t mk(pei_pkg::cmd_t c, logic [31:0] x, logic [31:0] y,
                                           logic [31:0] z, logic [19:0] dt);
    pei_pkg::in_item_t t;
    t.command = c; t.vector_x = x; t.vector_y = y; t.vector_z = z; t.duration = dt;
    return t;
  endfunction

  initial begin
    logic [31:0] imass[5];
    logic [31:0] dmp[5];
    imass = '{32'd65536, 32'h7fffffff, 32'd0, 32'hffff0000, 32'd3};
    dmp = '{32'd65536, 32'd0, 32'h1ffff, 32'd64881, 32'd1};
    repeat (11) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed
    send_item(mk(pei_pkg::CMD_POS, 32'h7fffffff, 32'h80000000, 32'd0, 20'd0));
    send_item(mk(pei_pkg::CMD_VEL, 32'h80000000, 32'h7fffffff, 32'h00010000, 20'hfffff));
    send_item(mk(pei_pkg::CMD_FORCE, 32'h7fffffff, 32'h80000000, 32'hffffffff, 20'd0));
    send_item(mk(pei_pkg::CMD_FORCE, 32'h7fffffff, 32'h80000000, 32'h00020000, 20'd0));
    send_item(mk(pei_pkg::CMD_STEP, 32'd0, 32'd0, 32'd0, 20'd0));
    send_item(mk(pei_pkg::CMD_STEP, 32'd0, 32'd0, 32'd0, 20'hfffff));
    send_item(mk(pei_pkg::CMD_STEP, 32'd0, 32'd0, 32'd0, 20'd1));
    send_item(mk(pei_pkg::CMD_STEP, 32'd0, 32'd0, 32'd0, 20'h10000));
    drain();
    write_cfg(pei_pkg::REG_INV_MASS, 32'd0);
    write_cfg(pei_pkg::reg_idx_t'(3'd7), 32'hdeadbeef);
    send_item(mk(pei_pkg::CMD_FORCE, 32'd65536, 32'd65536, 32'd65536, 20'd0));
    send_item(mk(pei_pkg::CMD_STEP, 32'd0, 32'd0, 32'd0, 20'h10000));
    drain();
    write_cfg(pei_pkg::REG_INV_MASS, 32'd65536);
    write_cfg(pei_pkg::REG_DAMPING, 32'd0);
    write_cfg(pei_pkg::REG_ACCEL_X, 32'h7fffffff);
    write_cfg(pei_pkg::REG_ACCEL_Y, 32'h80000000);
    write_cfg(pei_pkg::REG_ACCEL_Z, 32'hfff60000);
    send_item(mk(pei_pkg::CMD_VEL, 32'd65536, 32'd65536, 32'd65536, 20'd0));
    send_item(mk(pei_pkg::CMD_STEP, 32'd0, 32'd0, 32'd0, 20'd1));
    send_item(mk(pei_pkg::CMD_STEP, 32'd0, 32'd0, 32'd0, 20'd0));
    drain();

    // random phases through several settings
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(pei_pkg::REG_INV_MASS, ph < 5 ? imass[ph] : rand_val());
      write_cfg(pei_pkg::REG_DAMPING, ph < 5 ? dmp[ph] : 32'($urandom_range(0, 131071)));
      write_cfg(pei_pkg::REG_ACCEL_X, rand_val());
      write_cfg(pei_pkg::REG_ACCEL_Y, rand_val());
      write_cfg(pei_pkg::REG_ACCEL_Z, rand_val());
      if (ph == 2) hold_off = 1;
      if (ph == 7) calm = 1;
      for (int i = 0; i < 200; i++) send_item(rand_item());
      if (ph == 4) drain();
      drain();
    end

    while (sb.pending_states.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/pei_pkg.sv
rtl/particle_euler_integrator.sv
rtl/pei_checker.sv
tb/particle_euler_integrator_tb.sv
